@@ sv/medc_pkg.sv @@
`timescale 1ns / 1ps

package medc_pkg;

  localparam int SampleW  = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 13;
  localparam int RowWidthW = 13;

  // Register map
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_WIDTH = 1'd1;

  typedef logic [SampleW-1:0] sample_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // Median edge detector. a + b - c only applies when c lies strictly
  // between a and b, so the result fits in 8 bits.
  function automatic sample_t med_predict(input sample_t a, input sample_t b,
                                          input sample_t c);
    sample_t lo;
    sample_t hi;
    sample_t res;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      res = lo;
    end else if (c <= lo) begin
      res = hi;
    end else begin
      res = sample_t'(a + b - c);
    end
    return res;
  endfunction

endpackage

@@ sv/medc_line_buf.sv @@
`timescale 1ns / 1ps

// Previous-row buffer: one write and one read port, registered read,
// write-to-read bypass when both hit the same entry in the same cycle.
module medc_line_buf #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [medc_pkg::SampleW-1:0]  wdata_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [medc_pkg::SampleW-1:0]  rdata_o
);
  import medc_pkg::*;

  sample_t mem_q [Depth];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/med_predictive_residual_codec.sv @@
`timescale 1ns / 1ps
// Each result is registered and shows on the master side in the cycle after its input transfer.
// Throughput: one sample per cycle while the result side is not stalled; the left-pixel add/compare loop
//   closes through left_q, and the line buffer is read one column ahead so its registered data is ready.
// Reset (rst_ni low, async): output empty, column 0, first row, neighbors zero,
//   mode encode, row width 4096. Line buffer contents are not cleared.

module med_predictive_residual_codec #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [medc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [medc_pkg::CfgDataW-1:0]    cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] sample
  input  logic                             s_axis_tuser,  // [0] start_of_plane
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] value
  output logic                             m_axis_tlast   // end_of_row
);
  import medc_pkg::*;

  // Column counter width and a compare width that holds both the
  // configured width and the column count plus one.
  localparam int ColW = $clog2(MAX_ROW_WIDTH);
  localparam int CmpW = (ColW + 1 > RowWidthW) ? ColW + 1 : RowWidthW;

  // Config registers
  mode_e                 mode_q;
  logic [RowWidthW-1:0]  row_width_q;

  // Neighborhood state
  logic [ColW-1:0]       col_q, col_d;
  logic                  first_row_q, first_row_d;
  sample_t               left_q, left_d;
  sample_t               upleft_q, upleft_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  sample_t               out_data_q;
  logic                  out_last_q;

  logic                  in_xfer;
  logic [ColW-1:0]       col_cur;
  logic                  first_cur;
  sample_t               nb_a, nb_b, nb_c, pred, pixel, result;
  sample_t               upper_rd;
  logic [CmpW-1:0]       eff_width;
  logic [CmpW-1:0]       col_plus1;
  logic                  last;
  logic [ColW-1:0]       col_next;
  logic [ColW-1:0]       rd_addr;

  // Output register parts the two sides; a new transfer is taken while
  // the held result is being drained.
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCODE;
      row_width_q <= RowWidthW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q      <= mode_e'(cfg_data_i[0]);
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[RowWidthW-1:0];
        default:       ;
      endcase
    end
  end

  // Zero width acts as one, anything above the buffer depth saturates.
  always_comb begin
    if (row_width_q == '0) begin
      eff_width = CmpW'(1);
    end else if (CmpW'(row_width_q) > CmpW'(MAX_ROW_WIDTH)) begin
      eff_width = CmpW'(MAX_ROW_WIDTH);
    end else begin
      eff_width = CmpW'(row_width_q);
    end
  end

  // Start of plane restarts at column 0 on the first row.
  assign col_cur   = s_axis_tuser ? '0 : col_q;
  assign first_cur = s_axis_tuser | first_row_q;

  // Missing neighbors read as zero
  assign nb_a = (col_cur == '0) ? '0 : left_q;
  assign nb_b = first_cur ? '0 : upper_rd;
  assign nb_c = (first_cur || (col_cur == '0)) ? '0 : upleft_q;
  assign pred = med_predict(nb_a, nb_b, nb_c);

  always_comb begin
    case (mode_q)
      MODE_ENCODE: begin
        pixel  = s_axis_tdata;
        result = s_axis_tdata - pred;
      end
      MODE_DECODE: begin
        pixel  = s_axis_tdata + pred;
        result = pixel;
      end
      default: begin
        pixel  = s_axis_tdata;
        result = s_axis_tdata - pred;
      end
    endcase
  end

  // End of row also covers a width lowered below the current column.
  assign col_plus1 = CmpW'(col_cur) + CmpW'(1);
  assign last      = (col_plus1 >= eff_width);
  assign col_next  = last ? '0 : col_plus1[ColW-1:0];

  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    left_d      = left_q;
    upleft_d    = upleft_q;
    if (in_xfer) begin
      col_d       = col_next;
      first_row_d = last ? 1'b0 : first_cur;
      left_d      = last ? '0 : pixel;
      upleft_d    = last ? '0 : nb_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      left_q      <= '0;
      upleft_q    <= '0;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      left_q      <= left_d;
      upleft_q    <= upleft_d;
    end
  end

  // Read one column ahead so the upper pixel is registered in time.
  assign rd_addr = in_xfer ? col_next : col_q;

  medc_line_buf #(
    .Depth (MAX_ROW_WIDTH),
    .AddrW (ColW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (col_cur),
    .wdata_i (pixel),
    .raddr_i (rd_addr),
    .rdata_o (upper_rd)
  );

  assign out_valid_d = in_xfer | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= result;
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ sv/medc_checker.sv @@
`timescale 1ns / 1ps

module medc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [medc_pkg::SampleW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);
  import medc_pkg::*;

  // Held result stays put while the sink stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Every input transfer yields a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("missing result after input transfer");

  // No input is taken while a stalled result occupies the output register.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted over a stalled result");

  // With the output empty or draining the block is always ready.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("not ready with free output register");

endmodule

bind med_predictive_residual_codec medc_checker u_medc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
